// ===== design/set_assoc_cache_lru_defines.svh =====
// Assertion macros for the set-associative cache
`ifndef SET_ASSOC_CACHE_LRU_DEFINES_SVH
`define SET_ASSOC_CACHE_LRU_DEFINES_SVH
// implication checked at every clock edge outside reset
`define SAC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// implication checked in the cycle after the antecedent
`define SAC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

// ===== design/sac_pkg.sv =====
// Package with types and constants of the set-associative cache
`default_nettype none
package sac_pkg;
    localparam int NUM_SETS       = 16;
    localparam int NUM_WAYS       = 4;
    localparam int WORDS_PER_LINE = 4;
    localparam int ADDR_BITS      = 12;
    localparam int OFF_W  = (WORDS_PER_LINE > 1) ? $clog2(WORDS_PER_LINE) : 1;
    localparam int SET_W  = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
    localparam int WAY_W  = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
    localparam int WORD_W = ADDR_BITS - 2;
    localparam int TAG_W  = WORD_W - $clog2(WORDS_PER_LINE) - $clog2(NUM_SETS);
    localparam int TAG_WS = (TAG_W > 0) ? TAG_W : 1;
    localparam int LINE_W = $clog2(NUM_SETS * NUM_WAYS) > 0 ? $clog2(NUM_SETS * NUM_WAYS) : 1;
    localparam int LW_W   = $clog2(NUM_SETS * NUM_WAYS * WORDS_PER_LINE) > 0 ?
                            $clog2(NUM_SETS * NUM_WAYS * WORDS_PER_LINE) : 1;
    localparam int MEM_DEPTH = 1 << WORD_W;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_WRITE_ALLOCATE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WRITE_BACK     = 1'd1;
    localparam logic CMD_READ  = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    typedef struct packed {
        logic        command;
        logic [11:0] address;
        logic [31:0] write_data;
    } t_req;

    typedef struct packed {
        logic [31:0] read_data;
        logic        hit;
        logic        evicted_dirty;
        logic        memory_written;
        logic [31:0] hit_total;
    } t_rsp;

    // controller -> datapath
    typedef struct packed {
        logic load;       // capture request, start tag lookup
        logic decide;     // evaluate lookup results
        logic clr_step;   // step of reset clearing pass
        logic wb_step;    // write back one victim word
        logic fill_rd;    // issue memory read of one fill word
        logic fill_wr;    // store one fill word into line
        logic finish;     // update line, counters and result
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic clr_done;
        logic hit;
        logic alloc;
        logic dirty_victim;
        logic wb_last;
        logic fill_last;
    } t_sts;
endpackage
`default_nettype wire

// ===== design/set_assoc_cache_lru.sv =====
// Top level of the set-associative cache with LRU replacement, write-back by default
// Usage:
//   Requests enter on i_req_valid/o_req_ready with command, address and write data.
//   Each request yields one response on o_rsp_valid/i_rsp_ready with read data,
//   hit, dirty-eviction and memory-write flags, and the running hit count.
//   A hit or a write miss without allocate goes from lookup straight to the done
//   state, which moves the response into the output register; a miss first fills
//   the line word by word, each word read from the backing memory and then stored
//   into the line, and a dirty victim is written back word by word before the fill.
//   One request is in flight at a time; the next request is taken once the
//   response has moved into the output register, even while it waits there.
//   After reset the backing memory is cleared one word per cycle, all 1024 words,
//   before the first request is taken. Configuration writes are taken at any time.
//   When the receiver stalls, the response holds and the block finishes at most
//   one further request up to its done state, then waits.
`default_nettype none
module set_assoc_cache_lru import sac_pkg::*; (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_cfg_we,
    input  wire [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire                  i_cfg_data,
    input  wire                  i_req_valid,
    output logic                 o_req_ready,
    input  wire t_req            i_req,
    output logic                 o_rsp_valid,
    input  wire                  i_rsp_ready,
    output t_rsp                 o_rsp
);
    logic r_write_allocate, r_write_back;
    logic r_rsp_valid;
    t_cmd cmd;
    t_sts sts;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_write_allocate <= 1'b1;
            r_write_back     <= 1'b1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_WRITE_ALLOCATE: r_write_allocate <= i_cfg_data;
                CFG_WRITE_BACK:     r_write_back     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rsp_valid <= 1'b0;
        end else if (cmd.finish) begin
            r_rsp_valid <= 1'b1;
        end else if (i_rsp_ready) begin
            r_rsp_valid <= 1'b0;
        end
    end
    assign o_rsp_valid = r_rsp_valid;

    sac_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_ready (o_req_ready),
        .i_out_busy  (r_rsp_valid && !i_rsp_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    sac_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_req            (i_req),
        .i_write_allocate (r_write_allocate),
        .i_write_back     (r_write_back),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .o_rsp            (o_rsp)
    );
endmodule
`default_nettype wire

// ===== design/sac_ctrl.sv =====
// Controller state machine of the set-associative cache
`default_nettype none
`include "set_assoc_cache_lru_defines.svh"
module sac_ctrl import sac_pkg::*; (
    input  wire       i_clk,
    input  wire       i_rst_n,
    input  wire       i_req_valid,
    output logic      o_req_ready,
    input  wire       i_out_busy,
    input  wire t_sts i_sts,
    output t_cmd      o_cmd
);
    localparam logic [2:0] ST_CLEAR  = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_LOOKUP = 3'd2;
    localparam logic [2:0] ST_WB     = 3'd3;
    localparam logic [2:0] ST_FRD    = 3'd4;
    localparam logic [2:0] ST_FWR    = 3'd5;
    localparam logic [2:0] ST_DONE   = 3'd6;

    logic [2:0] r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_req_ready = 1'b0;
        unique case (r_state)
            ST_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_sts.clr_done) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_LOOKUP;
                end
            end
            ST_LOOKUP: begin
                o_cmd.decide = 1'b1;
                if (i_sts.hit || !i_sts.alloc) begin
                    n_state = ST_DONE;
                end else if (i_sts.dirty_victim) begin
                    n_state = ST_WB;
                end else begin
                    n_state = ST_FRD;
                end
            end
            ST_WB: begin
                o_cmd.wb_step = 1'b1;
                if (i_sts.wb_last) n_state = ST_FRD;
            end
            ST_FRD: begin
                o_cmd.fill_rd = 1'b1;
                n_state = ST_FWR;
            end
            ST_FWR: begin
                o_cmd.fill_wr = 1'b1;
                n_state = i_sts.fill_last ? ST_DONE : ST_FRD;
            end
            ST_DONE: begin
                if (!i_out_busy) begin
                    o_cmd.finish = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_CLEAR;
        endcase
    end

    `SAC_ASSERT_IMP(a_ready_idle, i_clk, i_rst_n, o_req_ready, r_state == ST_IDLE)
    `SAC_ASSERT_NXT(a_load_lookup, i_clk, i_rst_n, o_cmd.load, r_state == ST_LOOKUP)
    `SAC_ASSERT_IMP(a_finish_free, i_clk, i_rst_n, o_cmd.finish, !i_out_busy)
endmodule
`default_nettype wire

// ===== design/sac_dp.sv =====
// Datapath of the set-associative cache: line store, tags, stamps and backing memory
`default_nettype none
`include "set_assoc_cache_lru_defines.svh"
module sac_dp import sac_pkg::*; (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire t_req  i_req,
    input  wire        i_write_allocate,
    input  wire        i_write_back,
    input  wire t_cmd  i_cmd,
    output t_sts       o_sts,
    output t_rsp       o_rsp
);
    localparam int NL = NUM_SETS * NUM_WAYS;

    logic [NL-1:0]                   r_valid;
    logic [NL-1:0]                   r_dirty;
    logic [NUM_WAYS-1:0][TAG_WS-1:0] r_tag  [NUM_SETS];
    logic [NUM_WAYS-1:0][31:0]       r_stamp[NUM_SETS];
    logic [31:0]       line_mem[NL * WORDS_PER_LINE];
    logic [31:0]       back_mem[MEM_DEPTH];

    logic              r_cmd;
    logic [WORD_W-1:0] r_word;
    logic [31:0]       r_wdata;
    logic [31:0]       r_use, r_hits;
    logic              r_hit, r_evict;
    logic [WAY_W-1:0]  r_way;
    logic [OFF_W:0]    r_cnt;
    logic [WORD_W:0]   r_clr;
    logic [31:0]       r_mdata;
    logic [31:0]       r_ldata;
    logic [TAG_WS-1:0] r_vtag;

    logic [OFF_W-1:0]  a_off;
    logic [SET_W-1:0]  a_set;
    logic [TAG_WS-1:0] a_tag;
    logic [OFF_W-1:0]  cnt_off;

    assign a_off   = (WORDS_PER_LINE > 1) ? OFF_W'(r_word % WORDS_PER_LINE) : '0;
    assign a_set   = (NUM_SETS > 1) ? SET_W'((r_word / WORDS_PER_LINE) % NUM_SETS) : '0;
    assign a_tag   = TAG_WS'(r_word / (WORDS_PER_LINE * NUM_SETS));
    assign cnt_off = r_cnt[OFF_W-1:0];

    function automatic logic [LINE_W-1:0] line_of(logic [SET_W-1:0] s, logic [WAY_W-1:0] w);
        return LINE_W'(int'(s) * NUM_WAYS + int'(w));
    endfunction

    function automatic logic [WORD_W-1:0] mem_addr(logic [TAG_WS-1:0] t, logic [SET_W-1:0] s,
                                                   logic [OFF_W-1:0] o);
        return WORD_W'((int'(t) * NUM_SETS + int'(s)) * WORDS_PER_LINE + int'(o));
    endfunction

    // lookup and victim selection over the ways of one set
    logic [NUM_WAYS-1:0][TAG_WS-1:0] set_tags;
    logic [NUM_WAYS-1:0][31:0]       set_stamps;
    assign set_tags   = r_tag[a_set];
    assign set_stamps = r_stamp[a_set];

    logic             hit_c, inv_c;
    logic [WAY_W-1:0] hit_way, inv_way, old_way;
    logic [31:0]      old_stamp;
    always_comb begin
        hit_c = 1'b0; inv_c = 1'b0;
        hit_way = '0; inv_way = '0; old_way = '0;
        old_stamp = set_stamps[0];
        for (int w = 0; w < NUM_WAYS; w++) begin
            if (!hit_c && r_valid[line_of(a_set, WAY_W'(w))] &&
                set_tags[WAY_W'(w)] == a_tag) begin
                hit_c = 1'b1; hit_way = WAY_W'(w);
            end
            if (!inv_c && !r_valid[line_of(a_set, WAY_W'(w))]) begin
                inv_c = 1'b1; inv_way = WAY_W'(w);
            end
            if (w > 0 && set_stamps[WAY_W'(w)] < old_stamp) begin
                old_stamp = set_stamps[WAY_W'(w)];
                old_way = WAY_W'(w);
            end
        end
    end

    logic             alloc_c;
    logic [WAY_W-1:0] vic_way;
    assign alloc_c = (r_cmd == CMD_READ) || i_write_allocate;
    assign vic_way = inv_c ? inv_way : old_way;

    logic [LINE_W-1:0] cur_line;
    assign cur_line = line_of(a_set, r_way);

    always_comb begin
        o_sts = '0;
        o_sts.clr_done     = (r_clr == (WORD_W+1)'(MEM_DEPTH - 1));
        o_sts.hit          = hit_c;
        o_sts.alloc        = alloc_c;
        o_sts.dirty_victim = !inv_c && r_dirty[line_of(a_set, old_way)];
        o_sts.wb_last      = (r_cnt == (OFF_W+1)'(WORDS_PER_LINE - 1));
        o_sts.fill_last    = (r_cnt == (OFF_W+1)'(WORDS_PER_LINE - 1));
    end

    logic r_alloc;
    logic r_hit_or_alloc;
    logic r_memw_n;
    assign r_hit_or_alloc = r_hit || r_alloc;
    assign r_memw_n = (r_cmd == CMD_WRITE) && (!r_hit_or_alloc || !i_write_back);

    // backing memory: one write and one registered read per cycle
    logic              mem_we;
    logic [WORD_W-1:0] mem_wa;
    logic [31:0]       mem_wd;
    logic [WORD_W-1:0] mem_ra;
    always_comb begin
        mem_we = 1'b0; mem_wa = mem_addr(a_tag, a_set, cnt_off); mem_wd = r_ldata;
        mem_ra = mem_addr(a_tag, a_set, cnt_off);
        priority if (i_cmd.clr_step) begin
            mem_we = 1'b1; mem_wa = r_clr[WORD_W-1:0]; mem_wd = '0;
        end else if (i_cmd.wb_step) begin
            mem_we = 1'b1; mem_wa = mem_addr(r_vtag, a_set, cnt_off);
        end else if (i_cmd.finish && r_memw_n) begin
            mem_we = 1'b1; mem_wa = r_word; mem_wd = r_wdata;
        end else begin
            mem_we = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) back_mem[mem_wa] <= mem_wd;
        r_mdata <= back_mem[mem_ra];
    end

    // line word store: one write, one registered read per cycle
    logic              lw_we;
    logic [LW_W-1:0]   lw_wa, lw_ra;
    logic [31:0]       lw_wd;
    always_comb begin
        lw_we = 1'b0;
        lw_wa = LW_W'(int'(cur_line) * WORDS_PER_LINE + int'(cnt_off));
        lw_wd = r_mdata;
        lw_ra = LW_W'(int'(cur_line) * WORDS_PER_LINE + int'(cnt_off));
        if (i_cmd.fill_wr) begin
            lw_we = 1'b1;
        end else if (i_cmd.finish && r_cmd == CMD_WRITE && r_hit_or_alloc) begin
            lw_we = 1'b1;
            lw_wa = LW_W'(int'(cur_line) * WORDS_PER_LINE + int'(a_off));
            lw_wd = r_wdata;
        end
        if (i_cmd.decide) begin
            lw_ra = LW_W'(int'(line_of(a_set, hit_c ? hit_way : old_way)) * WORDS_PER_LINE +
                          (hit_c ? int'(a_off) : 0));
        end else if (i_cmd.fill_wr && o_sts.fill_last) begin
            lw_ra = LW_W'(int'(cur_line) * WORDS_PER_LINE + int'(a_off));
        end else if (i_cmd.wb_step) begin
            lw_ra = LW_W'(int'(cur_line) * WORDS_PER_LINE + int'(cnt_off) + 1);
        end
    end

    // hold the word at the offset for the response
    logic [31:0] r_lread;
    always_ff @(posedge i_clk) begin
        if (lw_we) line_mem[lw_wa] <= lw_wd;
        if (i_cmd.decide || (i_cmd.fill_wr && o_sts.fill_last)) begin
            r_lread <= (lw_we && lw_wa == lw_ra) ? lw_wd : line_mem[lw_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_dirty <= '0;
            r_use   <= '0;
            r_hits  <= '0;
            r_clr   <= '0;
            r_cnt   <= '0;
        end else begin
            if (i_cmd.clr_step) r_clr <= r_clr + 1'b1;
            if (i_cmd.load) begin
                r_cmd   <= i_req.command;
                r_word  <= i_req.address[ADDR_BITS-1:2];
                r_wdata <= i_req.write_data;
                r_cnt   <= '0;
            end
            if (i_cmd.decide) begin
                r_hit   <= hit_c;
                r_alloc <= !hit_c && alloc_c;
                r_evict <= !hit_c && alloc_c && !inv_c && r_dirty[line_of(a_set, old_way)];
                r_way   <= hit_c ? hit_way : vic_way;
                r_vtag  <= set_tags[old_way];
                r_cnt   <= '0;
            end
            if (i_cmd.wb_step) begin
                r_cnt <= o_sts.wb_last ? '0 : r_cnt + 1'b1;
            end
            if (i_cmd.fill_wr) begin
                r_cnt <= r_cnt + 1'b1;
                if (o_sts.fill_last) begin
                    r_valid[cur_line]    <= 1'b1;
                    r_dirty[cur_line]    <= 1'b0;
                    r_tag[a_set][r_way]  <= a_tag;
                end
            end
            if (i_cmd.finish) begin
                if (r_hit) r_hits <= r_hits + 1'b1;
                if (r_hit_or_alloc) begin
                    r_stamp[a_set][r_way] <= r_use;
                    r_use <= r_use + 1'b1;
                    if (r_cmd == CMD_WRITE && i_write_back) r_dirty[cur_line] <= 1'b1;
                end
            end
        end
    end

    // the line word buffer for write back is the read data one step ahead
    always_ff @(posedge i_clk) begin
        if (i_cmd.decide || i_cmd.wb_step) r_ldata <= line_mem[lw_ra];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            o_rsp.read_data      <= (r_cmd == CMD_READ) ? r_lread : '0;
            o_rsp.hit            <= r_hit;
            o_rsp.evicted_dirty  <= r_evict;
            o_rsp.memory_written <= r_memw_n;
            o_rsp.hit_total      <= r_hits + 32'(r_hit);
        end
    end

    `SAC_ASSERT_IMP(a_fill_cnt, i_clk, i_rst_n, i_cmd.fill_wr,
                    r_cnt < (OFF_W+1)'(WORDS_PER_LINE))
    `SAC_ASSERT_IMP(a_one_op, i_clk, i_rst_n, i_cmd.wb_step, !i_cmd.fill_wr && !i_cmd.finish)
    `SAC_ASSERT_NXT(a_fill_valid, i_clk, i_rst_n, i_cmd.fill_wr && o_sts.fill_last,
                    r_valid[$past(cur_line)])
endmodule
`default_nettype wire
